// ===== hdl/rida_pkg.sv =====
package rida_pkg;

  // default sizes
  localparam int NUM_IDS_DEF     = 1024;
  localparam int HANDLE_BITS_DEF = 32;

  // request selector codes
  localparam logic [1:0] FUNC_CREATE = 2'd0;
  localparam logic [1:0] FUNC_DELETE = 2'd1;
  localparam logic [1:0] FUNC_LOOKUP = 2'd2;

  // result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NO_FREE   = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;

  // controller to datapath commands
  typedef struct packed {
    logic clear_en;  // write one live map entry of the clearing pass
    logic accept;    // capture the item and issue the memory reads
    logic commit;    // update state, write memories, load the output register
  } ctrl_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic clear_last;  // clearing pass is at its last entry
    logic out_free;    // output register can take a result this cycle
  } dp_stat_t;

endpackage

// ===== hdl/recycling_id_allocator_table_unit.sv =====
// Recycling id allocator: create (func 0) issues a 1-based id, reusing the
// oldest deleted id first and then a high-water counter up to NUM_IDS, and
// stores the handle word with it; delete (func 1) frees a live id; look up
// (func 2) returns the stored handle word. Bad, dead or zero ids give status
// not found, as does the unused func 3; an exhausted pool gives no free id.
// Every item yields exactly one result item. An item is first captured while
// the live map, handle store and free-id fifo are read into registers; then
// it is decided, those memories are written and the output register is
// loaded once it is free; a new item is taken in the cycle after that and
// not before. After reset the live map is swept clear, one entry a cycle,
// over all NUM_IDS entries with s_axis_tready low.
module recycling_id_allocator_table_unit
  import rida_pkg::*;
#(
  parameter int NUM_IDS     = NUM_IDS_DEF,
  parameter int HANDLE_BITS = HANDLE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // item_id[31:0], handle_data[63:32]
  input  logic [1:0]  s_axis_tuser,   // func[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // result_id[31:0], stored_handle[63:32]
  output logic [1:0]  m_axis_tuser    // status[1:0]
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  // sequencer
  rida_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .stat          (stat),
    .cmd           (cmd)
  );

  // tables, fifo and output register
  rida_dpath #(
    .NUM_IDS     (NUM_IDS),
    .HANDLE_BITS (HANDLE_BITS)
  ) u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

// ===== hdl/rida_ctrl.sv =====
module rida_ctrl
  import rida_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      s_axis_tvalid,
  output logic      s_axis_tready,
  input  dp_stat_t  stat,
  output ctrl_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_CLEAR = 3'b001,
    S_IDLE  = 3'b010,
    S_EXEC  = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  // input side is open only between items
  assign s_axis_tready = (state == S_IDLE);

  // next state and commands
  always_comb begin
    state_next   = state;
    cmd.clear_en = 1'b0;
    cmd.accept   = 1'b0;
    cmd.commit   = 1'b0;
    case (state)
      S_CLEAR: begin
        cmd.clear_en = 1'b1;
        if (stat.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (s_axis_tvalid) begin
          cmd.accept = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== hdl/rida_dpath.sv =====
module rida_dpath
  import rida_pkg::*;
#(
  parameter int NUM_IDS     = NUM_IDS_DEF,
  parameter int HANDLE_BITS = HANDLE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  ctrl_cmd_t   cmd,
  output dp_stat_t    stat,
  input  logic [63:0] s_axis_tdata,   // item_id[31:0], handle_data[63:32]
  input  logic [1:0]  s_axis_tuser,   // func[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // result_id[31:0], stored_handle[63:32]
  output logic [1:0]  m_axis_tuser    // status[1:0]
);

  localparam int AW = (NUM_IDS > 1) ? $clog2(NUM_IDS) : 1;
  localparam int IW = $clog2(NUM_IDS + 1);
  localparam logic [AW-1:0] LAST_ADDR = AW'(NUM_IDS - 1);
  localparam logic [IW-1:0] MAX_ID    = IW'(NUM_IDS);

  // memories
  logic                   live_mem   [NUM_IDS];
  logic [HANDLE_BITS-1:0] handle_mem [NUM_IDS];
  logic [IW-1:0]          fifo_mem   [NUM_IDS];

  // control state
  logic [AW-1:0] clr_addr;
  logic [AW-1:0] fifo_head;
  logic [AW-1:0] fifo_tail;
  logic [IW-1:0] fifo_count;
  logic [IW-1:0] highest;

  // captured item and registered read data
  logic [1:0]             func_q;
  logic [IW-1:0]          id_q;
  logic [AW-1:0]          addr_q;
  logic                   id_ok_q;
  logic [HANDLE_BITS-1:0] handle_q;
  logic                   live_rd;
  logic [HANDLE_BITS-1:0] handle_rd;
  logic [IW-1:0]          fifo_rd;

  // incoming fields
  logic [31:0] in_id;
  logic [31:0] in_id_m1;
  logic [63:0] in_hd_wide;
  logic        in_id_ok;

  assign in_id      = s_axis_tdata[31:0];
  assign in_id_m1   = in_id - 32'd1;
  assign in_hd_wide = {32'd0, s_axis_tdata[63:32]};
  assign in_id_ok   = (in_id != 32'd0) && (in_id <= 32'(NUM_IDS));

  // capture the item and read all three memories
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      func_q    <= s_axis_tuser;
      id_q      <= in_id[IW-1:0];
      addr_q    <= in_id_m1[AW-1:0];
      id_ok_q   <= in_id_ok;
      handle_q  <= in_hd_wide[HANDLE_BITS-1:0];
      live_rd   <= live_mem[in_id_m1[AW-1:0]];
      handle_rd <= handle_mem[in_id_m1[AW-1:0]];
      fifo_rd   <= fifo_mem[fifo_head];
    end
  end

  // execute decision
  logic          new_ok;
  logic          pop;
  logic          bump;
  logic          push;
  logic          live_we;
  logic          live_wd;
  logic [AW-1:0] live_wa;
  logic          handle_we;
  logic [IW-1:0] nid;
  logic [IW-1:0] nid_m1;
  logic [1:0]             res_status;
  logic [IW-1:0]          res_id;
  logic [HANDLE_BITS-1:0] res_handle;

  assign nid    = (fifo_count != '0) ? fifo_rd : (highest + IW'(1));
  assign nid_m1 = nid - IW'(1);
  assign new_ok = (fifo_count != '0) || (highest < MAX_ID);

  always_comb begin
    pop        = 1'b0;
    bump       = 1'b0;
    push       = 1'b0;
    live_we    = 1'b0;
    live_wd    = 1'b0;
    live_wa    = addr_q;
    handle_we  = 1'b0;
    res_status = ST_NOT_FOUND;
    res_id     = '0;
    res_handle = '0;
    case (func_q)
      FUNC_CREATE: begin
        if (new_ok) begin
          pop        = (fifo_count != '0);
          bump       = (fifo_count == '0);
          live_we    = 1'b1;
          live_wd    = 1'b1;
          live_wa    = nid_m1[AW-1:0];
          handle_we  = 1'b1;
          res_status = ST_OK;
          res_id     = nid;
        end else begin
          res_status = ST_NO_FREE;
        end
      end
      FUNC_DELETE: begin
        if (id_ok_q && live_rd) begin
          live_we    = 1'b1;
          live_wd    = 1'b0;
          push       = (fifo_count < MAX_ID);
          res_status = ST_OK;
          res_id     = id_q;
        end
      end
      FUNC_LOOKUP: begin
        if (id_ok_q && live_rd) begin
          res_status = ST_OK;
          res_id     = id_q;
          res_handle = handle_rd;
        end
      end
      default: begin
        res_status = ST_NOT_FOUND;
      end
    endcase
  end

  // memory writes: clearing pass or commit
  always_ff @(posedge clk) begin
    if (cmd.clear_en) begin
      live_mem[clr_addr] <= 1'b0;
    end else if (cmd.commit && live_we) begin
      live_mem[live_wa] <= live_wd;
    end
    if (cmd.commit && handle_we) begin
      handle_mem[live_wa] <= handle_q;
    end
    if (cmd.commit && push) begin
      fifo_mem[fifo_tail] <= id_q;
    end
  end

  // pointers, counters and the clearing sweep
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr   <= '0;
      fifo_head  <= '0;
      fifo_tail  <= '0;
      fifo_count <= '0;
      highest    <= '0;
    end else begin
      if (cmd.clear_en) begin
        clr_addr <= clr_addr + AW'(1);
      end
      if (cmd.commit) begin
        if (pop) begin
          fifo_head  <= (fifo_head == LAST_ADDR) ? '0 : fifo_head + AW'(1);
          fifo_count <= fifo_count - IW'(1);
        end
        if (push) begin
          fifo_tail  <= (fifo_tail == LAST_ADDR) ? '0 : fifo_tail + AW'(1);
          fifo_count <= fifo_count + IW'(1);
        end
        if (bump) begin
          highest <= highest + IW'(1);
        end
      end
    end
  end

  // output register
  logic [63:0] res_handle_wide;

  assign res_handle_wide = 64'(res_handle);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (cmd.commit) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      m_axis_tuser <= res_status;
      m_axis_tdata <= {res_handle_wide[31:0], 32'(res_id)};
    end
  end

  // status to the controller
  assign stat.clear_last = (clr_addr == LAST_ADDR);
  assign stat.out_free   = !m_axis_tvalid || m_axis_tready;

endmodule

// ===== dv/tb.sv =====
module tb;
  import rida_pkg::*;

  localparam int NUM_IDS       = NUM_IDS_DEF;
  localparam int HANDLE_BITS   = HANDLE_BITS_DEF;
  localparam int SETTLE_CYCLES = 20;
  localparam int LIMIT_TIME    = 1000000;
  localparam int MAX_REPORTS   = 10;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] result_id;
    logic [31:0] stored_handle;
  } alloc_result_t;

  logic        clk           = 1'b0;
  logic        rst           = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata  = '0;  // item_id[31:0], handle_data[63:32]
  logic [1:0]  s_axis_tuser  = '0;  // func[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;        // result_id[31:0], stored_handle[63:32]
  logic [1:0]  m_axis_tuser;        // status[1:0]

  recycling_id_allocator_table_unit #(
    .NUM_IDS     (NUM_IDS),
    .HANDLE_BITS (HANDLE_BITS)
  ) dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // shadow copy of the allocator state
  bit          id_live_bit [NUM_IDS];
  bit   [31:0] id_handle   [NUM_IDS];
  bit   [10:0] freed_ring  [NUM_IDS];
  int          ring_head  = 0;
  int          ring_tail  = 0;
  int          ring_count = 0;
  int          high_water = 0;

  alloc_result_t pending_results[$];
  int            mismatch_count = 0;
  int            send_idle_pct  = 0;
  int            recv_idle_pct  = 0;

  // clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic bit id_in_use(logic [31:0] id);
    return (id != 0) && (id <= NUM_IDS) && id_live_bit[id - 1];
  endfunction

  // update the shadow state for one accepted item and queue its result
  task automatic apply_request(logic [1:0] fn, logic [31:0] id, logic [31:0] hdata);
    alloc_result_t r;
    int            nid;
    r   = '{status: ST_NOT_FOUND, result_id: '0, stored_handle: '0};
    nid = 0;
    case (fn)
      FUNC_CREATE: begin
        if (ring_count > 0) begin
          nid = int'(freed_ring[ring_head]);
          ring_head = (ring_head + 1) % NUM_IDS;
          ring_count--;
        end else if (high_water < NUM_IDS) begin
          high_water++;
          nid = high_water;
        end
        if (nid != 0) begin
          id_live_bit[nid - 1] = 1'b1;
          id_handle[nid - 1]   = hdata;
          r.status    = ST_OK;
          r.result_id = nid;
        end else begin
          r.status = ST_NO_FREE;
        end
      end
      FUNC_DELETE: begin
        if (id_in_use(id)) begin
          id_live_bit[id - 1] = 1'b0;
          if (ring_count < NUM_IDS) begin
            freed_ring[ring_tail] = id[10:0];
            ring_tail = (ring_tail + 1) % NUM_IDS;
            ring_count++;
          end
          r.status    = ST_OK;
          r.result_id = id;
        end
      end
      FUNC_LOOKUP: begin
        if (id_in_use(id)) begin
          r.status        = ST_OK;
          r.result_id     = id;
          r.stored_handle = id_handle[id - 1];
        end
      end
      default: ;
    endcase
    pending_results.push_back(r);
  endtask

  // drive one item at the falling edge and hold it until accepted
  task automatic send_item(logic [1:0] fn, logic [31:0] id, logic [31:0] hdata);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk);
    end
    s_axis_tdata  = {hdata, id};
    s_axis_tuser  = fn;
    s_axis_tvalid = 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    apply_request(fn, id, hdata);
    @(negedge clk);
  endtask

  // receiver back-pressure
  always @(negedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic report_mismatch(string what, alloc_result_t want, alloc_result_t got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("%s: expected status %0d id %h handle %h, got status %0d id %h handle %h",
               what, want.status, want.result_id, want.stored_handle,
               got.status, got.result_id, got.stored_handle);
    end
  endtask

  // compare each result item with the oldest expectation
  always @(posedge clk) begin
    alloc_result_t got;
    alloc_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = '{status: m_axis_tuser, result_id: m_axis_tdata[31:0],
              stored_handle: m_axis_tdata[63:32]};
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", '0, got);
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status || got.result_id !== want.result_id ||
            got.stored_handle !== want.stored_handle) begin
          report_mismatch("result mismatch", want, got);
        end
      end
    end
  end

  // pick an id to delete or look up: mostly plausible ids, some junk
  function automatic logic [31:0] pick_id();
    int sel;
    sel = $urandom_range(99);
    if (sel < 80 && high_water > 0) return $urandom_range(high_water, 1);
    if (sel < 85) return 32'd0;
    if (sel < 90) return NUM_IDS + 1;
    if (sel < 93) return 32'hFFFF_FFFF;
    return $urandom;
  endfunction

  // extremes, every operation and each corner on a fresh table
  task automatic test_directed();
    send_item(FUNC_LOOKUP, 32'd1, 32'h0);
    send_item(FUNC_DELETE, 32'd0, 32'hFFFF_FFFF);
    send_item(FUNC_CREATE, 32'hFFFF_FFFF, 32'h0000_0000);
    send_item(FUNC_CREATE, 32'd0, 32'hFFFF_FFFF);
    send_item(FUNC_CREATE, 32'd7, 32'hA5A5_5A5A);
    send_item(FUNC_LOOKUP, 32'd1, 32'h0);
    send_item(FUNC_LOOKUP, 32'd2, 32'hFFFF_FFFF);
    send_item(FUNC_LOOKUP, 32'd3, 32'h0);
    send_item(FUNC_LOOKUP, 32'd0, 32'h0);
    send_item(FUNC_LOOKUP, NUM_IDS, 32'h0);
    send_item(FUNC_LOOKUP, NUM_IDS + 1, 32'h0);
    send_item(FUNC_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(FUNC_DELETE, 32'd2, 32'h0);
    send_item(FUNC_DELETE, 32'd2, 32'h0);
    send_item(FUNC_LOOKUP, 32'd2, 32'h0);
    send_item(FUNC_DELETE, NUM_IDS + 1, 32'h0);
    send_item(FUNC_DELETE, 32'hFFFF_FFFF, 32'h0);
    // freed id comes back first
    send_item(FUNC_CREATE, 32'd0, 32'h1234_5678);
    send_item(FUNC_LOOKUP, 32'd2, 32'h0);
    // unused selector
    send_item(2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(2'd3, 32'd1, 32'h0);
    send_item(FUNC_DELETE, 32'd1, 32'h0);
    send_item(FUNC_DELETE, 32'd3, 32'h0);
    send_item(FUNC_CREATE, 32'd0, 32'h8000_0001);
    send_item(FUNC_CREATE, 32'd0, 32'h7FFF_FFFE);
    send_item(FUNC_CREATE, 32'd0, 32'hDEAD_BEEF);
  endtask

  // mixed traffic with random content
  task automatic test_random(int count, int create_pct);
    int i;
    int sel;
    logic [31:0] hdata;
    for (i = 0; i < count; i++) begin
      sel   = $urandom_range(99);
      hdata = $urandom;
      if (sel < create_pct) begin
        send_item(FUNC_CREATE, $urandom, hdata);
      end else if (sel < create_pct + 28) begin
        send_item(FUNC_DELETE, pick_id(), hdata);
      end else if (sel < 95) begin
        send_item(FUNC_LOOKUP, pick_id(), hdata);
      end else begin
        send_item(2'd3, $urandom, hdata);
      end
    end
  endtask

  // use up the whole pool, free part of it, then drain the reuse queue
  task automatic test_exhaust();
    int i;
    while (high_water < NUM_IDS || ring_count > 0) begin
      send_item(FUNC_CREATE, $urandom, $urandom);
    end
    for (i = 0; i < 3; i++) send_item(FUNC_CREATE, $urandom, $urandom);
    send_item(FUNC_LOOKUP, NUM_IDS, 32'h0);
    for (i = 0; i < 200; i++) begin
      send_item(FUNC_DELETE, $urandom_range(NUM_IDS, 1), $urandom);
    end
    while (ring_count > 0) begin
      send_item(FUNC_CREATE, $urandom, $urandom);
    end
    send_item(FUNC_CREATE, $urandom, $urandom);
    send_item(FUNC_CREATE, $urandom, $urandom);
  endtask

  // stimulus sequence
  initial begin
    repeat (10) @(negedge clk);
    rst = 1'b0;

    send_idle_pct = 9;
    recv_idle_pct = 66;
    test_directed();
    test_random(150, 45);

    send_idle_pct = 66;
    recv_idle_pct = 9;
    test_exhaust();
    test_random(150, 35);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(150, 37);

    s_axis_tvalid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #LIMIT_TIME;
    $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/rida_pkg.sv
hdl/rida_ctrl.sv
hdl/rida_dpath.sv
hdl/recycling_id_allocator_table_unit.sv
dv/tb.sv
